[rtl/htlp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_pkg
// Shared sizes, codes and controller/datapath interface types for the
// linear-probe hash table.
// ----------------------------------------------------------------------------
package htlp_pkg;

   // table geometry
   localparam int TABLE_SIZE = 97;
   localparam int KEY_CHARS  = 8;

   // field widths
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 7;

   // slot index and probe count
   localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

   // character sum and home slot reduction
   localparam int SUM_W   = $clog2(255 * KEY_CHARS + 1);
   localparam int RED_W   = SUM_W + 12;
   localparam int MOD_TOP = (SUM_W > IDX_W) ? (SUM_W - IDX_W) : 0;

   localparam logic [KEY_W-1:0] KEY_MASK = (KEY_CHARS >= 8) ? {KEY_W{1'b1}} :
      ((KEY_W'(1) << (8 * KEY_CHARS)) - KEY_W'(1));

   // request operation codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_MOD,
      S_READ,
      S_CHECK,
      S_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic sum;
      logic modulo;
      logic read;
      logic check;
      logic respond;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic probe_end;
      logic out_free;
   } dp_stat_type;

endpackage

[rtl/htlp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_ctrl
// Sequencer: request capture, hash, then read/check probe loop, then
// hand-off of the result to the response register.
// ----------------------------------------------------------------------------
module htlp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  htlp_pkg::dp_stat_type stat,
   output htlp_pkg::ctrl_cmd_type cmd
);

   htlp_pkg::state_type state_ff;
   htlp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htlp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         htlp_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = htlp_pkg::S_SUM;
            end
         end
         htlp_pkg::S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = htlp_pkg::S_MOD;
         end
         htlp_pkg::S_MOD: begin
            cmd.modulo = 1'b1;
            state_in   = htlp_pkg::S_READ;
         end
         htlp_pkg::S_READ: begin
            cmd.read = 1'b1;
            state_in = htlp_pkg::S_CHECK;
         end
         htlp_pkg::S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.probe_end ? htlp_pkg::S_RESULT : htlp_pkg::S_READ;
         end
         htlp_pkg::S_RESULT: begin
            // wait for the response register to free up
            if (stat.out_free) begin
               cmd.respond = 1'b1;
               state_in    = htlp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = htlp_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[rtl/htlp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_datapath
// Request registers, character-sum hash, probe index, valid bits, key and
// value memories, result staging and the response register.
// ----------------------------------------------------------------------------
module htlp_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  htlp_pkg::ctrl_cmd_type               cmd,
   output htlp_pkg::dp_stat_type                stat,
   input  logic                                 req_cmd,
   input  logic [htlp_pkg::KEY_W-1:0]           req_key,
   input  logic [htlp_pkg::VALUE_W-1:0]         req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [htlp_pkg::STATUS_W-1:0]        rsp_status,
   output logic [htlp_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [htlp_pkg::VALUE_W-1:0]         rsp_found_value
);

   // request
   logic                               op_ff;
   logic [htlp_pkg::KEY_W-1:0]         key_ff;
   logic [htlp_pkg::VALUE_W-1:0]       value_ff;

   // hash
   logic [htlp_pkg::SUM_W-1:0]         sum_ff;
   logic [htlp_pkg::SUM_W-1:0]         sum_in;
   logic [htlp_pkg::IDX_W-1:0]         home_in;

   // probe
   logic [htlp_pkg::IDX_W-1:0]         idx_ff;
   logic [htlp_pkg::IDX_W-1:0]         idx_next;
   logic [htlp_pkg::IDX_W-1:0]         tries_ff;
   logic                               last_try;
   logic                               probe_end;

   // table storage
   logic [htlp_pkg::TABLE_SIZE-1:0]    valid_ff;
   logic [htlp_pkg::KEY_W-1:0]         key_mem   [htlp_pkg::TABLE_SIZE];
   logic [htlp_pkg::VALUE_W-1:0]       value_mem [htlp_pkg::TABLE_SIZE];
   logic                               rd_valid_ff;
   logic [htlp_pkg::KEY_W-1:0]         rd_key_ff;
   logic [htlp_pkg::VALUE_W-1:0]       rd_value_ff;
   logic                               key_match;
   logic                               wr_en;

   // result staging and response
   htlp_pkg::status_type               res_status_in;
   logic [htlp_pkg::SLOT_W-1:0]        res_slot_in;
   logic [htlp_pkg::VALUE_W-1:0]       res_value_in;
   htlp_pkg::status_type               res_status_ff;
   logic [htlp_pkg::SLOT_W-1:0]        res_slot_ff;
   logic [htlp_pkg::VALUE_W-1:0]       res_value_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   htlp_pkg::status_type               rsp_status_ff;
   logic [htlp_pkg::SLOT_W-1:0]        rsp_slot_ff;
   logic [htlp_pkg::VALUE_W-1:0]       rsp_value_ff;

   // sum of the character codes
   always_comb begin
      sum_in = '0;
      for (int n = 0; n < htlp_pkg::KEY_CHARS; n++) begin
         sum_in = sum_in + htlp_pkg::SUM_W'(key_ff[8*n +: 8]);
      end
   end

   // sum modulo table size by restoring subtraction of shifted constants
   always_comb begin
      logic [htlp_pkg::RED_W-1:0] rem;
      rem = htlp_pkg::RED_W'(sum_ff);
      for (int i = htlp_pkg::MOD_TOP; i >= 0; i--) begin
         if (rem >= (htlp_pkg::RED_W'(htlp_pkg::TABLE_SIZE) << i)) begin
            rem = rem - (htlp_pkg::RED_W'(htlp_pkg::TABLE_SIZE) << i);
         end
      end
      home_in = htlp_pkg::IDX_W'(rem);
   end

   // probe step with wraparound
   assign idx_next  = (idx_ff == htlp_pkg::IDX_W'(htlp_pkg::TABLE_SIZE - 1)) ?
                      '0 : (idx_ff + htlp_pkg::IDX_W'(1));
   assign last_try  = (tries_ff == htlp_pkg::IDX_W'(htlp_pkg::TABLE_SIZE - 1));
   assign key_match = (rd_key_ff == key_ff);
   assign wr_en     = cmd.check && (op_ff == htlp_pkg::CMD_INSERT) && !rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_cmd;
         key_ff   <= req_key & htlp_pkg::KEY_MASK;
         value_ff <= req_value;
      end
      if (cmd.sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.modulo) begin
         idx_ff   <= home_in;
         tries_ff <= '0;
      end else if (cmd.check) begin
         idx_ff   <= idx_next;
         tries_ff <= tries_ff + htlp_pkg::IDX_W'(1);
      end
   end

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   // key and value memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[idx_ff]   <= key_ff;
         value_mem[idx_ff] <= value_ff;
      end
      if (cmd.read) begin
         rd_valid_ff <= valid_ff[idx_ff];
         rd_key_ff   <= key_mem[idx_ff];
         rd_value_ff <= value_mem[idx_ff];
      end
   end

   // probe outcome
   always_comb begin
      probe_end     = 1'b0;
      res_status_in = htlp_pkg::ST_NOT_FOUND;
      res_slot_in   = '0;
      res_value_in  = '0;
      if (op_ff == htlp_pkg::CMD_INSERT) begin
         if (!rd_valid_ff) begin
            probe_end     = 1'b1;
            res_status_in = htlp_pkg::ST_INSERTED;
            res_slot_in   = htlp_pkg::SLOT_W'(idx_ff);
         end else if (last_try) begin
            probe_end     = 1'b1;
            res_status_in = htlp_pkg::ST_FULL;
         end
      end else begin
         if (!rd_valid_ff) begin
            probe_end = 1'b1;
         end else if (key_match) begin
            probe_end     = 1'b1;
            res_status_in = htlp_pkg::ST_FOUND;
            res_slot_in   = htlp_pkg::SLOT_W'(idx_ff);
            res_value_in  = rd_value_ff;
         end else if (last_try) begin
            probe_end = 1'b1;
         end
      end
   end

   assign stat.probe_end = probe_end;

   always_ff @(posedge clock) begin
      if (cmd.check && probe_end) begin
         res_status_ff <= res_status_in;
         res_slot_ff   <= res_slot_in;
         res_value_ff  <= res_value_in;
      end
   end

   // response register
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in  = cmd.respond ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_found_value = rsp_value_ff;

endmodule

[rtl/hash_table_linear_probe_unit.sv]
`timescale 1ns / 1ps
// steps from accept to response valid: sum, mod, read/check per slot probed, result
// one request at a time, probing from 1 up to the table size (97) slots
// each probe is a registered read of the key/value memories, then a check
// the response register lets the next request be accepted while a response is stalled
// reset (synchronous) clears the controller, the response valid and all slot valid bits;
// the block takes requests in the first cycle after reset
// ----------------------------------------------------------------------------
// hash_table_linear_probe_unit
// Open-addressing symbol table with linear probing. A request inserts a key
// and value or searches for a key; each request yields one response.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [htlp_pkg::KEY_W-1:0]           req_key,
   input  logic [htlp_pkg::VALUE_W-1:0]         req_value,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [htlp_pkg::STATUS_W-1:0]        rsp_status,
   output logic [htlp_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [htlp_pkg::VALUE_W-1:0]         rsp_found_value
);

   // command and status between sequencer and datapath
   htlp_pkg::ctrl_cmd_type cmd;
   htlp_pkg::dp_stat_type  stat;

   // sequencer: idle -> sum -> mod -> (read -> check)* -> result
   htlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: hash, probe index, table storage and response register
   htlp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_found_value (rsp_found_value)
   );

endmodule
